// ----- sv/assert_macros.svh -----
// Assertion macros shared by the sorted key table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SAT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sat_pkg.sv -----
// Shared types and constants of the sorted key table.
package sat_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int FIELD_W       = 5;
	localparam int OUT_FIELDS_W  = 2 + 1 + FIELD_W + FIELD_W;
	localparam int OUT_DATA_W    = 16;

	typedef enum logic [1:0] {
		FUNC_INSERT   = 2'd0,
		FUNC_FIND     = 2'd1,
		FUNC_WITHDRAW = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		RD_INS_START = 3'd0,
		RD_INS_NEXT  = 3'd1,
		RD_MID       = 3'd2,
		RD_DEL_START = 3'd3,
		RD_DEL_NEXT  = 3'd4
	} rd_sel_t;

	typedef enum logic [2:0] {
		RES_KEEP      = 3'd0,
		RES_MISS      = 3'd1,
		RES_FULL      = 3'd2,
		RES_EMPTY     = 3'd3,
		RES_NOT_FOUND = 3'd4,
		RES_HIT       = 3'd5,
		RES_INS       = 3'd6
	} res_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		logic    ins_init;
		logic    ins_shift;
		logic    ins_place;
		logic    srch_init;
		logic    mid_load;
		logic    go_right;
		logic    go_left;
		logic    del_init;
		logic    del_step;
		logic    del_done;
		res_t    res;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic idx_zero;
		logic probe_gt_key;
		logic probe_eq_key;
		logic key_gt_probe;
		logic srch_open;
		logic del_more;
		logic out_free;
	} stat_t;

endpackage

// ----- sv/sat_ctrl.sv -----
// Controller state machine of the sorted key table.
module sat_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       s_tuser,
	input  sat_pkg::stat_t   stat,
	output sat_pkg::cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_INS      = 6'b000010,
		S_SRCH_RD  = 6'b000100,
		S_SRCH_CMP = 6'b001000,
		S_DEL      = 6'b010000,
		S_FIN      = 6'b100000
	} state_t;

	state_t     state_q;
	state_t     state_next;
	logic [1:0] func_q;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= s_tuser;
		end
	end

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					unique case (s_tuser)
						sat_pkg::FUNC_INSERT: begin
							if (stat.full) begin
								cmd.res    = sat_pkg::RES_FULL;
								state_next = S_FIN;
							end else begin
								cmd.ins_init = 1'b1;
								cmd.rd_sel   = sat_pkg::RD_INS_START;
								state_next   = S_INS;
							end
						end
						sat_pkg::FUNC_FIND: begin
							cmd.srch_init = 1'b1;
							state_next    = S_SRCH_RD;
						end
						sat_pkg::FUNC_WITHDRAW: begin
							if (stat.empty) begin
								cmd.res    = sat_pkg::RES_EMPTY;
								state_next = S_FIN;
							end else begin
								cmd.srch_init = 1'b1;
								state_next    = S_SRCH_RD;
							end
						end
						default: begin
							cmd.res    = sat_pkg::RES_MISS;
							state_next = S_FIN;
						end
					endcase
				end
			end
			S_INS: begin
				if (stat.idx_zero || !stat.probe_gt_key) begin
					cmd.ins_place = 1'b1;
					cmd.res       = sat_pkg::RES_INS;
					state_next    = S_FIN;
				end else begin
					cmd.ins_shift = 1'b1;
					cmd.rd_sel    = sat_pkg::RD_INS_NEXT;
				end
			end
			S_SRCH_RD: begin
				if (stat.srch_open) begin
					cmd.mid_load = 1'b1;
					cmd.rd_sel   = sat_pkg::RD_MID;
					state_next   = S_SRCH_CMP;
				end else begin
					if (func_q == sat_pkg::FUNC_WITHDRAW) begin
						cmd.res = sat_pkg::RES_NOT_FOUND;
					end else begin
						cmd.res = sat_pkg::RES_MISS;
					end
					state_next = S_FIN;
				end
			end
			S_SRCH_CMP: begin
				if (stat.probe_eq_key) begin
					cmd.res = sat_pkg::RES_HIT;
					if (func_q == sat_pkg::FUNC_WITHDRAW) begin
						cmd.del_init = 1'b1;
						cmd.rd_sel   = sat_pkg::RD_DEL_START;
						state_next   = S_DEL;
					end else begin
						state_next = S_FIN;
					end
				end else if (stat.key_gt_probe) begin
					cmd.go_right = 1'b1;
					state_next   = S_SRCH_RD;
				end else begin
					cmd.go_left = 1'b1;
					state_next  = S_SRCH_RD;
				end
			end
			S_DEL: begin
				if (stat.del_more) begin
					cmd.del_step = 1'b1;
					cmd.rd_sel   = sat_pkg::RD_DEL_NEXT;
				end else begin
					cmd.del_done = 1'b1;
					state_next   = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/sat_dpath.sv -----
// Datapath of the sorted key table: key memory, search bounds and result register.
module sat_dpath #(
	parameter int DEPTH     = sat_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = sat_pkg::KEY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [KEY_WIDTH-1:0]           key,
	input  sat_pkg::cmd_t                  cmd,
	output sat_pkg::stat_t                 stat,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sat_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int PAD_W = sat_pkg::OUT_DATA_W - sat_pkg::OUT_FIELDS_W;

	logic [KEY_WIDTH-1:0] mem_q [DEPTH];
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] rdata_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hp1_q;
	logic [CW-1:0]        mid_q;
	logic [CW-1:0]        pos_q;
	sat_pkg::status_t     status_q;
	logic                 found_q;
	logic                 m_tvalid_q;
	logic [sat_pkg::OUT_DATA_W-1:0] out_q;

	logic [CW:0]          mid_sum;
	logic [CW-1:0]        mid_next;
	logic [CW-1:0]        raddr_full;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic [KEY_WIDTH-1:0] wdata;
	logic                 we;
	logic [CW+sat_pkg::FIELD_W-1:0] pos_ext;
	logic [CW+sat_pkg::FIELD_W-1:0] count_ext;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hp1_q} - (CW + 1)'(1);
	assign mid_next = mid_sum[CW:1];

	always_comb begin
		unique case (cmd.rd_sel)
			sat_pkg::RD_INS_START: raddr_full = count_q - CW'(1);
			sat_pkg::RD_INS_NEXT:  raddr_full = idx_q - CW'(2);
			sat_pkg::RD_MID:       raddr_full = mid_next;
			sat_pkg::RD_DEL_START: raddr_full = mid_q + CW'(1);
			sat_pkg::RD_DEL_NEXT:  raddr_full = idx_q + CW'(2);
			default:               raddr_full = mid_next;
		endcase
	end

	assign raddr = raddr_full[AW-1:0];
	assign waddr = idx_q[AW-1:0];
	assign we    = cmd.ins_shift | cmd.ins_place | cmd.del_step;
	assign wdata = cmd.ins_place ? key_q : rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.ins_place) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.del_done) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
		end
		if (cmd.ins_init) begin
			idx_q <= count_q;
		end else if (cmd.ins_shift) begin
			idx_q <= idx_q - CW'(1);
		end else if (cmd.del_init) begin
			idx_q <= mid_q;
		end else if (cmd.del_step) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.srch_init) begin
			lo_q  <= '0;
			hp1_q <= count_q;
		end else if (cmd.go_right) begin
			lo_q <= mid_q + CW'(1);
		end else if (cmd.go_left) begin
			hp1_q <= mid_q;
		end
		if (cmd.mid_load) begin
			mid_q <= mid_next;
		end
		case (cmd.res)
			sat_pkg::RES_MISS: begin
				status_q <= sat_pkg::ST_OK;
				found_q  <= 1'b0;
				pos_q    <= count_q;
			end
			sat_pkg::RES_FULL: begin
				status_q <= sat_pkg::ST_FULL;
				found_q  <= 1'b0;
				pos_q    <= count_q;
			end
			sat_pkg::RES_EMPTY: begin
				status_q <= sat_pkg::ST_EMPTY;
				found_q  <= 1'b0;
				pos_q    <= '0;
			end
			sat_pkg::RES_NOT_FOUND: begin
				status_q <= sat_pkg::ST_NOT_FOUND;
				found_q  <= 1'b0;
				pos_q    <= count_q;
			end
			sat_pkg::RES_HIT: begin
				status_q <= sat_pkg::ST_OK;
				found_q  <= 1'b1;
				pos_q    <= mid_q;
			end
			sat_pkg::RES_INS: begin
				status_q <= sat_pkg::ST_OK;
				found_q  <= 1'b0;
				pos_q    <= idx_q;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			out_q <= {{PAD_W{1'b0}}, count_ext[sat_pkg::FIELD_W-1:0],
				pos_ext[sat_pkg::FIELD_W-1:0], found_q, status_q};
		end
	end

	assign pos_ext   = {{sat_pkg::FIELD_W{1'b0}}, pos_q};
	assign count_ext = {{sat_pkg::FIELD_W{1'b0}}, count_q};

	assign stat.full         = (count_q >= CW'(DEPTH));
	assign stat.empty        = (count_q == '0);
	assign stat.idx_zero     = (idx_q == '0);
	assign stat.probe_gt_key = (rdata_q > key_q);
	assign stat.probe_eq_key = (rdata_q == key_q);
	assign stat.key_gt_probe = (key_q > rdata_q);
	assign stat.srch_open    = (lo_q < hp1_q);
	assign stat.del_more     = ((idx_q + CW'(1)) < count_q);
	assign stat.out_free     = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

// ----- sv/sorted_array_table.sv -----
// Top level of the sorted key table with insert, find and withdraw.
//
//  Channel  Direction  Contents
//  s_*      in         tuser: func; tdata: key
//  m_*      out        tdata: status, found, offset, entries_after
//
// Insert moves each key larger than the new one up one slot, then places the key.
// Find runs a binary search over the stored keys. A withdraw that hits moves the
// keys above it down one slot; a full, empty or unused request skips the search.
// The key memory does one read and at most one write per cycle.
// Reset clears the entry count and the output valid; the key memory needs no clearing.
// A new transfer is taken once the previous result is in the output register.
`include "assert_macros.svh"

module sorted_array_table #(
	parameter int DEPTH     = sat_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = sat_pkg::KEY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// key
	input  logic [((KEY_WIDTH+7)/8)*8-1:0] s_tdata,
	// func
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status, found, offset, entries_after
	output logic [sat_pkg::OUT_DATA_W-1:0] m_tdata
);

	sat_pkg::cmd_t  cmd;
	sat_pkg::stat_t stat;

	sat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	sat_dpath #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (s_tdata[KEY_WIDTH-1:0]),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`SAT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "transfer taken while busy")
	`SAT_ASSERT_IMP(a_place_not_full, cmd.ins_place, !stat.full, "insert into a full table")
	`SAT_ASSERT_IMP(a_del_not_empty, cmd.del_step || cmd.del_done, !stat.empty, "shift on empty table")

endmodule
